>>> sv/cpat_pkg.sv
`timescale 1ns / 1ps
package cpat_pkg;

	localparam int FRAC_BITS_DEF   = 12;
	localparam int ANGLE_ITERS_DEF = 16;
	localparam int TABLE_LEN       = 24;
	localparam int CFG_IDX_W       = 3;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_POS = 3'd0,
		REG_KD_POS = 3'd1,
		REG_KP_ATT = 3'd2,
		REG_KD_ATT = 3'd3,
		REG_MASS   = 3'd4,
		REG_INV_MG = 3'd5,
		REG_PLIM   = 3'd6,
		REG_ALIM   = 3'd7
	} cfg_reg_t;

	localparam logic [15:0] MASS_RST  = 16'd1786;
	localparam logic [15:0] INV_RST   = 16'd2215;
	localparam logic signed [33:0] PI_Q30   = 34'sd3373259426;
	localparam logic signed [21:0] GRAV_Q16 = 22'sd642908;

	typedef struct packed {
		logic signed [14:0] yaw_target;
		logic [47:0] rate_xyz;
		logic [63:0] quat_wxyz;
		logic [47:0] vel_err_xyz;
		logic [47:0] pos_err_xyz;
	} cpat_in_t;

	typedef struct packed {
		logic signed [15:0] thrust_cmd;
		logic signed [15:0] yaw_torque;
		logic signed [15:0] pitch_torque;
		logic signed [15:0] roll_torque;
	} cpat_out_t;

	// arctangent table, Q30
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		unique case (i)
			5'd0:  atan_q30 = 34'sd843314856;
			5'd1:  atan_q30 = 34'sd497837829;
			5'd2:  atan_q30 = 34'sd263043836;
			5'd3:  atan_q30 = 34'sd133525158;
			5'd4:  atan_q30 = 34'sd67021686;
			5'd5:  atan_q30 = 34'sd33543515;
			5'd6:  atan_q30 = 34'sd16775850;
			5'd7:  atan_q30 = 34'sd8388437;
			5'd8:  atan_q30 = 34'sd4194282;
			5'd9:  atan_q30 = 34'sd2097149;
			5'd10: atan_q30 = 34'sd1048575;
			5'd11: atan_q30 = 34'sd524287;
			5'd12: atan_q30 = 34'sd262143;
			5'd13: atan_q30 = 34'sd131071;
			5'd14: atan_q30 = 34'sd65535;
			5'd15: atan_q30 = 34'sd32767;
			5'd16: atan_q30 = 34'sd16383;
			5'd17: atan_q30 = 34'sd8191;
			5'd18: atan_q30 = 34'sd4095;
			5'd19: atan_q30 = 34'sd2047;
			5'd20: atan_q30 = 34'sd1023;
			5'd21: atan_q30 = 34'sd511;
			5'd22: atan_q30 = 34'sd255;
			5'd23: atan_q30 = 34'sd127;
			default: atan_q30 = 34'sd0;
		endcase
	endfunction

endpackage

>>> sv/cascaded_pd_attitude_thrust.sv
`timescale 1ns / 1ps
// Cascaded PD position/attitude controller. One transaction is taken per
// clock (busy stays low); each result appears on result with done high for
// exactly one cycle, in order. The receiver cannot stall: results must be
// taken as they appear. The input-to-result delay is set by the pitch path
// (two operand stages, square root pipeline of 29 stages, then ANGLE_ITERS+1
// CORDIC stages) plus one merge stage and the three-stage torque lanes.
// Configuration writes are always ready and take effect on the next cycle;
// write only when idle.
module cascaded_pd_attitude_thrust
	import cpat_pkg::*;
#(
	parameter int ANGLE_ITERS = ANGLE_ITERS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cpat_pkg::cpat_in_t item,
	output logic done,
	output cpat_pkg::cpat_out_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [47:0] cfg_data
);
	localparam int FB = FRAC_BITS_DEF;
	localparam int ANG_SH = 30 - FB;
	localparam int SQ_LAT = 29;
	localparam int CD_LAT = ANGLE_ITERS + 1;
	localparam int A_LAT = 2 + SQ_LAT + CD_LAT; // angle ready at this stage
	localparam int T_LAT = A_LAT + 1 + 3;       // total latency

	logic [47:0] kp_pos_q, kd_pos_q, kp_att_q, kd_att_q;
	logic [15:0] mass_q, inv_q, plim_q, alim_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_pos_q <= '0; kd_pos_q <= '0; kp_att_q <= '0; kd_att_q <= '0;
			mass_q <= MASS_RST; inv_q <= INV_RST; plim_q <= '0; alim_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KP_POS: kp_pos_q <= cfg_data;
				REG_KD_POS: kd_pos_q <= cfg_data;
				REG_KP_ATT: kp_att_q <= cfg_data;
				REG_KD_ATT: kd_att_q <= cfg_data;
				REG_MASS:   mass_q <= cfg_data[15:0];
				REG_INV_MG: inv_q <= cfg_data[15:0];
				REG_PLIM:   plim_q <= cfg_data[15:0];
				REG_ALIM:   alim_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// valid shift line
	logic [T_LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[T_LAT-2:0], start};
	end
	assign done = vld_q[T_LAT-1];

	wire signed [15:0] qw = item.quat_wxyz[15:0];
	wire signed [15:0] qx = item.quat_wxyz[31:16];
	wire signed [15:0] qy = item.quat_wxyz[47:32];
	wire signed [15:0] qz = item.quat_wxyz[63:48];

	// stage 1: quaternion products and outer PD products
	logic signed [32:0] ra_s1, rb_s1, pa_s1, ya_s1, yb_s1;
	logic signed [33:0] pe_s1 [3];
	logic signed [14:0] yt_s1;
	logic signed [15:0] rt_s1 [3];
	always_ff @(posedge clk) begin
		ra_s1 <= 33'(qw * qx) + 33'(qy * qz);
		rb_s1 <= 33'(qx * qx) + 33'(qy * qy);
		pa_s1 <= 33'(qw * qy) - 33'(qx * qz);
		ya_s1 <= 33'(qw * qz) + 33'(qx * qy);
		yb_s1 <= 33'(qy * qy) + 33'(qz * qz);
		yt_s1 <= item.yaw_target;
		for (int k = 0; k < 3; k++) begin
			pe_s1[k] <= 34'($signed({1'b0, kp_pos_q[16*k +: 16]}) *
				$signed(item.pos_err_xyz[16*k +: 16])) +
				34'($signed({1'b0, kd_pos_q[16*k +: 16]}) *
				$signed(item.vel_err_xyz[16*k +: 16]));
			rt_s1[k] <= item.rate_xyz[16*k +: 16];
		end
	end

	// stage 2: atan2 operands, sine clamp, square root operand
	logic signed [33:0] ry_s2, rx_s2, yy_s2, yx_s2, s_s2;
	logic [56:0] sq_s2;
	logic signed [33:0] s_c;
	logic signed [59:0] s_sq;
	always_comb begin
		s_c = 34'(pa_s1) <<< 1;
		if (s_c > 34'sd268435456) s_c = 34'sd268435456;
		if (s_c < -34'sd268435456) s_c = -34'sd268435456;
		s_sq = $signed(s_c[29:0]) * $signed(s_c[29:0]);
	end
	always_ff @(posedge clk) begin
		ry_s2 <= 34'(ra_s1) <<< 1;
		rx_s2 <= 34'sd268435456 - (34'(rb_s1) <<< 1);
		yy_s2 <= 34'(ya_s1) <<< 1;
		yx_s2 <= 34'sd268435456 - (34'(yb_s1) <<< 1);
		s_s2  <= s_c;
		sq_s2 <= 57'(60'sh100000000000000 - s_sq);
	end

	// delay roll/yaw operands and sine to match the root pipeline
	logic signed [33:0] ry_d [SQ_LAT], rx_d [SQ_LAT], yy_d [SQ_LAT],
		yx_d [SQ_LAT], s_d [SQ_LAT];
	always_ff @(posedge clk) begin
		ry_d[0] <= ry_s2; rx_d[0] <= rx_s2; yy_d[0] <= yy_s2;
		yx_d[0] <= yx_s2; s_d[0] <= s_s2;
		for (int i = 1; i < SQ_LAT; i++) begin
			ry_d[i] <= ry_d[i-1]; rx_d[i] <= rx_d[i-1]; yy_d[i] <= yy_d[i-1];
			yx_d[i] <= yx_d[i-1]; s_d[i] <= s_d[i-1];
		end
	end
	logic [28:0] c_root;
	cpat_isqrt u_sqrt (.clk(clk), .v_in(sq_s2), .r_out(c_root));

	logic signed [33:0] z_roll, z_pitch, z_yaw;
	// the isqrt output aligns with the last delay tap
	cpat_cordic #(.ITERS(ANGLE_ITERS)) u_roll (.clk(clk),
		.y_in(ry_d[SQ_LAT-1]), .x_in(rx_d[SQ_LAT-1]), .z_out(z_roll));
	cpat_cordic #(.ITERS(ANGLE_ITERS)) u_pitch (.clk(clk),
		.y_in(s_d[SQ_LAT-1]), .x_in($signed({5'd0, c_root})), .z_out(z_pitch));
	cpat_cordic #(.ITERS(ANGLE_ITERS)) u_yaw (.clk(clk),
		.y_in(yy_d[SQ_LAT-1]), .x_in(yx_d[SQ_LAT-1]), .z_out(z_yaw));

	// delay outer PD products, target and rates alongside the angle path
	localparam int DD = A_LAT - 1;
	logic signed [33:0] pe_d [DD][3];
	logic signed [14:0] yt_d [DD];
	logic signed [15:0] rt_d [DD][3];
	always_ff @(posedge clk) begin
		pe_d[0] <= pe_s1; yt_d[0] <= yt_s1; rt_d[0] <= rt_s1;
		for (int i = 1; i < DD; i++) begin
			pe_d[i] <= pe_d[i-1]; yt_d[i] <= yt_d[i-1]; rt_d[i] <= rt_d[i-1];
		end
	end

	// merge: round angles, outer clamps, yaw wrap, thrust product
	localparam logic signed [21:0] PI_F = 22'(((64'sd3373259426) +
		(64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH);
	logic signed [21:0] roll_a, pitch_a, yaw_a, dyaw;
	logic signed [26:0] u_r [3];
	logic signed [26:0] uc_r [3];
	logic signed [19:0] arg_s [3];
	logic signed [53:0] thr_base;
	always_comb begin
		roll_a  = 22'((35'(z_roll)  + (35'sd1 <<< (ANG_SH - 1))) >>> ANG_SH);
		pitch_a = 22'((35'(z_pitch) + (35'sd1 <<< (ANG_SH - 1))) >>> ANG_SH);
		yaw_a   = 22'((35'(z_yaw)   + (35'sd1 <<< (ANG_SH - 1))) >>> ANG_SH);
		for (int k = 0; k < 3; k++) begin
			u_r[k] = 27'((pe_d[DD-1][k] + 34'sd128) >>> 8);
			uc_r[k] = u_r[k];
			if (uc_r[k] > $signed({11'd0, plim_q})) uc_r[k] = $signed({11'd0, plim_q});
			if (uc_r[k] < -$signed({11'd0, plim_q})) uc_r[k] = -$signed({11'd0, plim_q});
		end
		dyaw = yaw_a - 22'(yt_d[DD-1]);
		if (dyaw >= PI_F) dyaw = dyaw - (PI_F <<< 1);
		else if (dyaw < -PI_F) dyaw = dyaw + (PI_F <<< 1);
		arg_s[0] = 20'(roll_a + 22'(uc_r[1]));
		arg_s[1] = 20'(pitch_a - 22'(uc_r[0]));
		arg_s[2] = 20'(dyaw);
		thr_base = -54'($signed({1'b0, mass_q}) * GRAV_Q16) + (54'(u_r[2]) <<< 16);
	end

	logic signed [19:0] arg_s3 [3];
	logic signed [15:0] rate_s3 [3];
	logic signed [53:0] thr_s3;
	always_ff @(posedge clk) begin
		arg_s3 <= arg_s;
		rate_s3 <= rt_d[DD-1];
		thr_s3 <= thr_base;
	end

	logic signed [15:0] tq [3];
	for (genvar k = 0; k < 3; k++) begin : g_lane
		cpat_lane u_lane (.clk(clk), .kp(kp_att_q[16*k +: 16]),
			.kd(kd_att_q[16*k +: 16]), .arg(arg_s3[k]), .rate(rate_s3[k]),
			.inv_gain(inv_q), .alim(alim_q), .torque(tq[k]));
	end

	// thrust lane, matched to torque lane latency
	logic signed [71:0] tp_s4;
	logic signed [39:0] tr;
	logic signed [15:0] thr_s5, thr_s6;
	always_comb begin
		tr = 40'((tp_s4 + 72'sh80000000) >>> 32);
		if (tr < -$signed({24'd0, alim_q})) tr = -$signed({24'd0, alim_q});
		else if (tr >= 0) tr = '0;
		if (tr < -40'sd32768) tr = -40'sd32768;
	end
	always_ff @(posedge clk) begin
		tp_s4 <= 72'(thr_s3) * $signed({1'b0, inv_q});
		thr_s5 <= 16'(tr);
		thr_s6 <= thr_s5;
	end

	assign result.roll_torque  = tq[0];
	assign result.pitch_torque = tq[1];
	assign result.yaw_torque   = tq[2];
	assign result.thrust_cmd   = thr_s6;

	a_thr_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.thrust_cmd <= 16'sd0)
		else $error("thrust sign");
	a_zero_alim: assert property (@(posedge clk) disable iff (!arst_n)
		(done && alim_q == 0 && $stable(alim_q)) |-> result == '0)
		else $error("output above zero limit");
	a_done_track: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(T_LAT) done)
		else $error("result lost");

endmodule

>>> sv/cpat_cordic.sv
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring atan2, one micro-rotation per stage.
// Result in Q30.
module cpat_cordic #(
	parameter int ITERS = 16
) (
	input  logic clk,
	input  logic signed [33:0] y_in,
	input  logic signed [33:0] x_in,
	output logic signed [33:0] z_out
);
	import cpat_pkg::*;

	logic signed [35:0] xs [ITERS+1];
	logic signed [35:0] ys [ITERS+1];
	logic signed [34:0] zs [ITERS+1];

	// pre-rotate the left half plane
	always_ff @(posedge clk) begin
		if (x_in < 0) begin
			xs[0] <= -36'(x_in);
			ys[0] <= -36'(y_in);
			zs[0] <= (y_in >= 0) ? 35'(PI_Q30) : -35'(PI_Q30);
		end else begin
			xs[0] <= 36'(x_in);
			ys[0] <= 36'(y_in);
			zs[0] <= '0;
		end
	end

	for (genvar i = 0; i < ITERS; i++) begin : g_stage
		localparam int SH = (i < TABLE_LEN) ? i : 0;
		localparam logic [4:0] IDX = 5'(SH);
		// advance one micro-rotation; skip when y is zero or past the table
		always_ff @(posedge clk) begin
			if (ys[i] == 0 || i >= TABLE_LEN) begin
				xs[i+1] <= xs[i];
				ys[i+1] <= ys[i];
				zs[i+1] <= zs[i];
			end else if (ys[i] > 0) begin
				xs[i+1] <= xs[i] + (ys[i] >>> SH);
				ys[i+1] <= ys[i] - (xs[i] >>> SH);
				zs[i+1] <= zs[i] + 35'(atan_q30(IDX));
			end else begin
				xs[i+1] <= xs[i] - (ys[i] >>> SH);
				ys[i+1] <= ys[i] + (xs[i] >>> SH);
				zs[i+1] <= zs[i] - 35'(atan_q30(IDX));
			end
		end
	end

	assign z_out = 34'(zs[ITERS]);

endmodule

>>> sv/cpat_isqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root of a 57-bit value, one result bit per stage.
module cpat_isqrt (
	input  logic clk,
	input  logic [56:0] v_in,
	output logic [28:0] r_out
);
	localparam int STEPS = 29;

	logic [56:0] rem [STEPS+1];
	logic [28:0] root [STEPS+1];

	assign rem[0]  = v_in;
	assign root[0] = '0;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam int B = STEPS - 1 - i;
		logic [58:0] trial;
		assign trial = ({30'd0, root[i]} << (B + 1)) + (59'd1 << (2 * B));
		// decide one root bit
		always_ff @(posedge clk) begin
			if ({2'b00, rem[i]} >= trial) begin
				rem[i+1]  <= rem[i] - 57'(trial);
				root[i+1] <= root[i] | (29'd1 << B);
			end else begin
				rem[i+1]  <= rem[i];
				root[i+1] <= root[i];
			end
		end
	end

	assign r_out = root[STEPS];

endmodule

>>> sv/cpat_lane.sv
`timescale 1ns / 1ps
// One attitude torque lane: PD term, motor scaling, clamp.
module cpat_lane (
	input  logic clk,
	input  logic [15:0] kp,
	input  logic [15:0] kd,
	input  logic signed [19:0] arg,
	input  logic signed [15:0] rate,
	input  logic [15:0] inv_gain,
	input  logic [15:0] alim,
	output logic signed [15:0] torque
);
	logic signed [37:0] pd_s1;
	logic signed [55:0] sc_s2;
	logic signed [32:0] sh;
	logic signed [15:0] t_s3;

	// clamp to limit then to output range
	function automatic logic signed [32:0] out_sat(input logic signed [32:0] v);
		logic signed [32:0] l;
		logic signed [32:0] c;
		l = $signed({17'd0, alim});
		c = v;
		if (c > l) c = l;
		if (c < -l) c = -l;
		if (c > 33'sd32767) c = 33'sd32767;
		if (c < -33'sd32768) c = -33'sd32768;
		out_sat = c;
	endfunction

	// round half up by 24
	assign sh = 33'((sc_s2 + 56'sd8388608) >>> 24);

	always_ff @(posedge clk) begin
		pd_s1 <= 38'($signed({1'b0, kp}) * arg) + 38'($signed({1'b0, kd}) * rate);
		sc_s2 <= 56'(pd_s1) * $signed({1'b0, inv_gain});
		t_s3  <= 16'(out_sat(sh));
	end

	assign torque = t_s3;

endmodule
